[hw/rtl/ssnf_pkg.sv]
`default_nettype none

package ssnf_pkg;

	// Configuration register indexes.
	localparam logic CFG_UPPER_LIMIT = 1'b0;
	localparam logic CFG_LOWER_LIMIT = 1'b1;

	// Reset values of the limit registers.
	localparam logic [30:0]        UPPER_LIMIT_RST = 31'd9999;
	localparam logic signed [31:0] LOWER_LIMIT_RST = -32'sd1999;

	// Character codes.
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_COLON = 7'h3A;
	localparam logic [6:0] CH_UPPER_E = 7'h45;
	localparam logic [6:0] CH_LOWER_R = 7'h72;
	localparam logic [6:0] CH_UPPER_D = 7'h44;

	// Number of decimal digits of a 32-bit magnitude.
	localparam int DIGITS = 10;

	// Display form chosen at the front of the pipeline.
	typedef enum logic [1:0] {
		FORM_PLAIN = 2'd0,
		FORM_EXPO  = 2'd1,
		FORM_ERR   = 2'd2,
		FORM_HEX   = 2'd3
	} form_t;

	// Per-item fields that ride along with the conversion.
	typedef struct packed {
		form_t       form;
		logic        neg;
		logic [1:0]  dot;
		logic [2:0]  idx;
		logic [15:0] hex;
	} ctl_t;

	// One pipeline beat: control, BCD accumulator and remaining binary bits.
	typedef struct packed {
		ctl_t        ctl;
		logic [39:0] bcd;
		logic [31:0] bin;
	} pipe_t;

	// One shift-and-add-3 step of the binary to BCD conversion.
	function automatic logic [39:0] dd_step(logic [39:0] bcd, logic din);
		logic [39:0] b;
		b = bcd;
		for (int k = 0; k < DIGITS; k++) begin
			if (b[4*k +: 4] >= 4'd5) begin
				b[4*k +: 4] = b[4*k +: 4] + 4'd3;
			end
		end
		return {b[38:0], din};
	endfunction

	// Eight conversion steps, consuming the top byte of the binary word.
	function automatic pipe_t dd_byte(pipe_t p);
		pipe_t r;
		r = p;
		for (int i = 0; i < 8; i++) begin
			r.bcd = dd_step(r.bcd, r.bin[31]);
			r.bin = {r.bin[30:0], 1'b0};
		end
		return r;
	endfunction

	// ASCII for a decimal digit.
	function automatic logic [6:0] digit_char(logic [3:0] d);
		return CH_ZERO + {3'b000, d};
	endfunction

	// ASCII for a hexadecimal digit.
	function automatic logic [6:0] hex_char(logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {3'b000, d};
		end else begin
			c = CH_UPPER_A + {3'b000, d - 4'd10};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/seven_segment_number_formatter.sv]
`default_nettype none

// Formats a 32-bit number into four ASCII characters and a decimal-point
// position for a seven-segment display. Decimal mode shows values between
// lower_limit and upper_limit as four digits with leading blanks suppressed
// down to the dot, values above the upper limit or nonnegative values below
// the lower limit as two leading digits and a signed exponent, and negative
// values below the lower limit as "ErrD"; hex mode shows the low 16 bits.
// The block is a six-stage pipeline: one stage classifies the value and
// takes its magnitude, four stages each convert one byte of the magnitude to
// BCD, and an output register holds the characters. It accepts one beat per
// clock while it has room; the last stage holds a result while out_ready is
// low and the pipeline keeps filling behind it. Write the limits (index 0
// upper, index 1 lower) only while the pipeline is empty.
module seven_segment_number_formatter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               mode,
	input  wire logic signed [31:0] value,
	input  wire logic [1:0]         dot,
	input  wire logic [2:0]         display_index,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [6:0]              char_0,
	output logic [6:0]              char_1,
	output logic [6:0]              char_2,
	output logic [6:0]              char_3,
	output logic [1:0]              point_position,
	output logic [2:0]              target_display
);
	import ssnf_pkg::*;

	logic [30:0]        upper_limit_q;
	logic signed [31:0] lower_limit_q;
	logic               prep_valid, prep_ready;
	pipe_t              prep_pipe;
	logic               conv_valid, conv_ready;
	pipe_t              conv_pipe;

	assign cfg_ready = 1'b1;

	// Limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_limit_q <= UPPER_LIMIT_RST;
			lower_limit_q <= LOWER_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_UPPER_LIMIT: upper_limit_q <= cfg_data[30:0];
				CFG_LOWER_LIMIT: lower_limit_q <= cfg_data;
				default: begin
					upper_limit_q <= upper_limit_q;
				end
			endcase
		end
	end

	ssnf_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.value         (value),
		.dot           (dot),
		.display_index (display_index),
		.upper_limit   (upper_limit_q),
		.lower_limit   (lower_limit_q),
		.out_valid     (prep_valid),
		.out_ready     (prep_ready),
		.out_pipe      (prep_pipe)
	);

	ssnf_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.in_pipe   (prep_pipe),
		.out_valid (conv_valid),
		.out_ready (conv_ready),
		.out_pipe  (conv_pipe)
	);

	ssnf_glyph u_glyph (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (conv_valid),
		.in_ready       (conv_ready),
		.in_pipe        (conv_pipe),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.char_0         (char_0),
		.char_1         (char_1),
		.char_2         (char_2),
		.char_3         (char_3),
		.point_position (point_position),
		.target_display (target_display)
	);

endmodule

`default_nettype wire

[hw/rtl/ssnf_prep.sv]
`default_nettype none

module ssnf_prep (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                mode,
	input  wire logic signed [31:0]  value,
	input  wire logic [1:0]          dot,
	input  wire logic [2:0]          display_index,
	input  wire logic [30:0]         upper_limit,
	input  wire logic signed [31:0]  lower_limit,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output ssnf_pkg::pipe_t          out_pipe
);
	import ssnf_pkg::*;

	logic        above;
	logic        below;
	logic [31:0] mag;
	pipe_t       next_pipe;
	logic        valid_s1;
	pipe_t       pipe_s1;

	// Classify the value against the limits and take its magnitude.
	always_comb begin
		above = $signed({value[31], value}) > $signed({2'b00, upper_limit});
		below = value < lower_limit;
		mag   = value[31] ? (~value + 32'd1) : value;

		next_pipe.ctl.neg = value[31];
		next_pipe.ctl.dot = dot;
		next_pipe.ctl.idx = display_index;
		next_pipe.ctl.hex = value[15:0];
		next_pipe.bcd     = '0;
		next_pipe.bin     = mag;
		if (mode) begin
			next_pipe.ctl.form = FORM_HEX;
		end else if (above) begin
			next_pipe.ctl.form = FORM_EXPO;
		end else if (below) begin
			next_pipe.ctl.form = value[31] ? FORM_ERR : FORM_EXPO;
		end else begin
			next_pipe.ctl.form = FORM_PLAIN;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pipe_s1 <= next_pipe;
		end
	end

	assign out_valid = valid_s1;
	assign out_pipe  = pipe_s1;

endmodule

`default_nettype wire

[hw/rtl/ssnf_dabble.sv]
`default_nettype none

module ssnf_dabble (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ssnf_pkg::pipe_t in_pipe,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ssnf_pkg::pipe_t      out_pipe
);
	import ssnf_pkg::*;

	logic  valid_s2, valid_s3, valid_s4, valid_s5;
	pipe_t pipe_s2, pipe_s3, pipe_s4, pipe_s5;
	logic  adv2, adv3, adv4, adv5;

	// A stage loads when it is empty or its contents move on.
	assign adv5     = !valid_s5 || out_ready;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign in_ready = adv2;

	// Valid bits of the four conversion stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= in_valid;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
			if (adv5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Each stage converts one byte of the magnitude.
	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			pipe_s2 <= dd_byte(in_pipe);
		end
		if (adv3 && valid_s2) begin
			pipe_s3 <= dd_byte(pipe_s2);
		end
		if (adv4 && valid_s3) begin
			pipe_s4 <= dd_byte(pipe_s3);
		end
		if (adv5 && valid_s4) begin
			pipe_s5 <= dd_byte(pipe_s4);
		end
	end

	assign out_valid = valid_s5;
	assign out_pipe  = pipe_s5;

endmodule

`default_nettype wire

[hw/rtl/ssnf_glyph.sv]
`default_nettype none

module ssnf_glyph (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ssnf_pkg::pipe_t in_pipe,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [6:0]           char_0,
	output logic [6:0]           char_1,
	output logic [6:0]           char_2,
	output logic [6:0]           char_3,
	output logic [1:0]           point_position,
	output logic [2:0]           target_display
);
	import ssnf_pkg::*;

	logic [3:0]        dg [DIGITS];
	logic [3:0]        lead_idx;
	logic signed [4:0] expo;
	logic [4:0]        expo_abs;
	logic              nz_ten, nz_hund, nz_thou;
	logic [6:0]        c0, c1, c2, c3;
	logic [1:0]        pp;
	logic              valid_s6;
	logic [6:0]        char0_s6, char1_s6, char2_s6, char3_s6;
	logic [1:0]        point_s6;
	logic [2:0]        target_s6;

	// Split the BCD word and find the leading nonzero digit.
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < DIGITS; i++) begin
			dg[i] = in_pipe.bcd[4*i +: 4];
			if (in_pipe.bcd[4*i +: 4] != 4'd0) begin
				lead_idx = 4'(i);
			end
		end
		nz_thou = in_pipe.bcd[39:12] != '0;
		nz_hund = nz_thou || (dg[2] != 4'd0);
		nz_ten  = nz_hund || (dg[1] != 4'd0);
		expo     = $signed({1'b0, lead_idx}) - $signed({3'b000, in_pipe.ctl.dot});
		expo_abs = expo[4] ? 5'(-expo) : expo;
	end

	// Build the four characters for the selected form.
	always_comb begin
		c0 = CH_SPACE;
		c1 = CH_SPACE;
		c2 = CH_SPACE;
		c3 = CH_SPACE;
		pp = 2'd3;
		case (in_pipe.ctl.form)
			FORM_HEX: begin
				c0 = hex_char(in_pipe.ctl.hex[15:12]);
				c1 = hex_char(in_pipe.ctl.hex[11:8]);
				c2 = hex_char(in_pipe.ctl.hex[7:4]);
				c3 = hex_char(in_pipe.ctl.hex[3:0]);
				pp = 2'd0;
			end
			FORM_ERR: begin
				c0 = CH_UPPER_E;
				c1 = CH_LOWER_R;
				c2 = CH_LOWER_R;
				c3 = CH_UPPER_D;
			end
			FORM_EXPO: begin
				c0 = digit_char(dg[lead_idx]);
				c1 = (lead_idx == 4'd0) ? CH_ZERO : digit_char(dg[lead_idx - 4'd1]);
				c2 = expo[4] ? CH_MINUS : CH_SPACE;
				c3 = digit_char(expo_abs[3:0]);
			end
			FORM_PLAIN: begin
				// A negative value puts its sign in the thousands place when that
				// digit is zero; a colon stands for minus one thousand.
				if (in_pipe.ctl.neg) begin
					if (dg[3] == 4'd0) begin
						c0 = CH_MINUS;
					end else if (dg[3] == 4'd1) begin
						c0 = CH_COLON;
					end else begin
						c0 = digit_char(dg[3]);
					end
				end else begin
					c0 = (nz_thou || in_pipe.ctl.dot > 2'd2) ? digit_char(dg[3]) : CH_SPACE;
				end
				c1 = (nz_hund || in_pipe.ctl.dot > 2'd1) ? digit_char(dg[2]) : CH_SPACE;
				c2 = (nz_ten || in_pipe.ctl.dot > 2'd0) ? digit_char(dg[1]) : CH_SPACE;
				c3 = digit_char(dg[0]);
				pp = in_pipe.ctl.dot;
			end
			default: begin
				pp = 2'd3;
			end
		endcase
	end

	assign in_ready = !valid_s6 || out_ready;

	// Output stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (in_ready) begin
			valid_s6 <= in_valid;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char0_s6  <= c0;
			char1_s6  <= c1;
			char2_s6  <= c2;
			char3_s6  <= c3;
			point_s6  <= pp;
			target_s6 <= in_pipe.ctl.idx;
		end
	end

	assign out_valid      = valid_s6;
	assign char_0         = char0_s6;
	assign char_1         = char1_s6;
	assign char_2         = char2_s6;
	assign char_3         = char3_s6;
	assign point_position = point_s6;
	assign target_display = target_s6;

endmodule

`default_nettype wire
